[src/gwat_pkg.sv]
// ----------------------------------------------------------------------------
// gwat_pkg
// Shared widths, register indexes, reset values and the result struct of the
// windowed gyro average with throttle command.
// ----------------------------------------------------------------------------
package gwat_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 8;
  localparam int AVG_W    = 24;
  localparam int CMD_W    = 8;
  localparam int DB_W     = 9;
  localparam int FS_W     = 11;
  localparam int MD_W     = 7;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = FS_W;

  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY   = 2'd2;

  localparam logic [DB_W-1:0] DEADBAND_RST   = 9'd10;
  localparam logic [FS_W-1:0] FULL_SCALE_RST = 11'd500;
  localparam logic [MD_W-1:0] MAX_DUTY_RST   = 7'd100;

  // command scaling
  localparam int DB_SHIFT  = 24;
  localparam int CMD_SHIFT = 23;
  localparam logic [CMD_W-1:0] CMD_LIMIT = 8'd100;

  // average magnitude and sign handed from the divider to the scaler
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [AVG_W-1:0] mag;
  } gwat_avg_t;

endpackage

[src/gyro_window_average_throttle_top.sv]
// ----------------------------------------------------------------------------
// gyro_window_average_throttle_top
// Boxcar average of gyro X over a sample ring with an exact running sum,
// and a deadbanded, scaled motor duty command.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------
//   input    | in_valid / in_ready       | gyro_x
//   output   | out_valid / out_ready     | average_q8, motor_command,
//            |                           | window_full
//   config   | cfg_we (no wait)          | cfg_index, cfg_data
//
// Each item passes the sum, load and divide steps, with one quotient bit a
// cycle, and the bit-serial command step, then waits in the hold step until
// its result beat is loaded into the output register.
// One item is worked on at a time; the next is taken as soon as the
// previous one sits in the output register.
// A stalled output holds the next finished item in the scaler until the
// output register frees up. Reset clears control state and loads the
// register defaults; the ring needs no clearing pass.
// ----------------------------------------------------------------------------
module gyro_window_average_throttle_top import gwat_pkg::*; #(
  parameter int WINDOW_LEN = 50
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  gyro_x,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [AVG_W-1:0]     average_q8,
  output logic signed [CMD_W-1:0]     motor_command,
  output logic                        window_full,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_CMD  = 3'd4;
  localparam logic [2:0] ST_HOLD = 3'd5;

  logic [2:0]                 state;
  logic [2:0]                 state_next;

  logic [DB_W-1:0]            deadband;
  logic [FS_W-1:0]            full_scale;
  logic [MD_W-1:0]            max_duty;

  logic signed [SAMPLE_W-1:0] ring [WINDOW_LEN];
  logic signed [SAMPLE_W-1:0] old_sample;
  logic signed [SAMPLE_W-1:0] sample;
  logic [IDX_W-1:0]           write_index;
  logic                       filled;
  logic signed [SUM_W-1:0]    running_sum;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           idx_inc;
  logic                       wrap;

  gwat_avg_t                  avg;
  logic                       scale_done;
  logic signed [CMD_W-1:0]    cmd;
  logic [AVG_W-1:0]           avg_mag;
  logic                       avg_neg;
  logic                       out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband   <= DEADBAND_RST;
      full_scale <= FULL_SCALE_RST;
      max_duty   <= MAX_DUTY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEADBAND:   deadband   <= cfg_data[DB_W-1:0];
        REG_FULL_SCALE: full_scale <= cfg_data[FS_W-1:0];
        REG_MAX_DUTY:   max_duty   <= cfg_data[MD_W-1:0];
        default: ;
      endcase
    end
  end

  // sample ring: oldest entry read on accept, new sample written in the sum step
  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      ring[write_index] <= sample;
    end
    old_sample <= ring[write_index];
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample <= gyro_x;
    end
  end

  assign idx_inc = CNT_W'(write_index) + 1'b1;
  assign wrap    = (idx_inc == CNT_W'(WINDOW_LEN));

  // running sum, window position and divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      filled      <= 1'b0;
      running_sum <= '0;
    end else if (state == ST_SUM) begin
      running_sum <= running_sum + SUM_W'(sample)
                     - (filled ? SUM_W'(old_sample) : SUM_W'(0));
      write_index <= wrap ? IDX_W'(0) : IDX_W'(idx_inc);
      if (wrap) begin
        filled <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      count <= filled ? CNT_W'(WINDOW_LEN) : idx_inc;
    end
  end

  // serial divider and command scaler
  gwat_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_LOAD),
    .sum   (running_sum),
    .count (count),
    .res   (avg)
  );

  gwat_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .avg        (avg),
    .deadband   (deadband),
    .full_scale (full_scale),
    .max_duty   (max_duty),
    .done       (scale_done),
    .cmd        (cmd)
  );

  // keep the average until the beat is loaded
  always_ff @(posedge clk) begin
    if (avg.valid) begin
      avg_mag <= avg.mag;
      avg_neg <= avg.neg;
    end
  end

  // sequencer
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_SUM;
      ST_SUM:  state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV:  if (avg.valid) state_next = ST_CMD;
      ST_CMD:  if (scale_done) state_next = ST_HOLD;
      ST_HOLD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && out_free) begin
      average_q8    <= avg_neg ? AVG_W'(-avg_mag) : avg_mag;
      motor_command <= cmd;
      window_full   <= filled;
    end
  end

  // checks
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(write_index) < CNT_W'(WINDOW_LEN))
    else $error("write index beyond window");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    avg.valid |-> state == ST_DIV)
    else $error("divider result outside divide step");

  a_scale_in_cmd: assert property (@(posedge clk) disable iff (rst)
    scale_done |-> state == ST_CMD)
    else $error("scaler result outside command step");

  a_accept_sum: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == ST_SUM)
    else $error("accepted beat not summed");

endmodule

[src/gwat_div.sv]
// ----------------------------------------------------------------------------
// gwat_div
// Bit-serial restoring divider: |sum| * 256 / count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module gwat_div import gwat_pkg::*; #(
  parameter int SUM_W = 22,
  parameter int CNT_W = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum,
  input  logic        [CNT_W-1:0] count,
  output gwat_avg_t               res
);

  localparam int DVD_W  = SUM_W + FRAC_W;
  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DVD_W-1:0]  dvd;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  divisor;
  logic              neg;

  logic [SUM_W-1:0]  sum_mag;
  logic [CNT_W:0]    trial;
  logic              fits;

  // magnitude of the signed sum
  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  // partial remainder with the next dividend bit shifted in
  assign trial = {rem, dvd[DVD_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // iteration: dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(DVD_W);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd     <= {sum_mag, {FRAC_W{1'b0}}};
      rem     <= '0;
      divisor <= count;
      neg     <= sum[SUM_W-1];
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], fits};
      if (fits) begin
        rem <= CNT_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[CNT_W-1:0];
      end
    end
  end

  assign res.valid = done;
  assign res.neg   = neg;
  assign res.mag   = dvd[AVG_W-1:0];

endmodule

[src/gwat_scale.sv]
// ----------------------------------------------------------------------------
// gwat_scale
// Bit-serial shift-add products of the average magnitude with full scale and
// duty, then deadband test, saturation and sign of the motor command.
// ----------------------------------------------------------------------------
module gwat_scale import gwat_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  gwat_avg_t               avg,
  input  logic [DB_W-1:0]         deadband,
  input  logic [FS_W-1:0]         full_scale,
  input  logic [MD_W-1:0]         max_duty,
  output logic                    done,
  output logic signed [CMD_W-1:0] cmd
);

  localparam int STEP_W = $clog2(FS_W + 1);
  localparam int ACC_FS_W = AVG_W + FS_W;
  localparam int ACC_MD_W = AVG_W + MD_W;
  localparam int LIM_W = DB_W + DB_SHIFT;

  logic                busy;
  logic                fin;
  logic [STEP_W-1:0]   step;
  logic [AVG_W-1:0]    mag;
  logic                neg;
  logic [FS_W-1:0]     fs_sh;
  logic [FS_W-1:0]     md_sh;
  logic [ACC_FS_W-1:0] acc_fs;
  logic [ACC_MD_W-1:0] acc_md;

  logic [LIM_W-1:0]    limit;
  logic [CMD_W-1:0]    raw_mag;
  logic [CMD_W-1:0]    cmd_mag;

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      fin  <= 1'b0;
      done <= fin;
      if (avg.valid) begin
        busy <= 1'b1;
        step <= STEP_W'(FS_W);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // msb-first shift-add of both products
  always_ff @(posedge clk) begin
    if (avg.valid) begin
      mag    <= avg.mag;
      neg    <= avg.neg;
      fs_sh  <= full_scale;
      md_sh  <= FS_W'(max_duty);
      acc_fs <= '0;
      acc_md <= '0;
    end else if (busy) begin
      fs_sh  <= {fs_sh[FS_W-2:0], 1'b0};
      md_sh  <= {md_sh[FS_W-2:0], 1'b0};
      acc_fs <= {acc_fs[ACC_FS_W-2:0], 1'b0} + (fs_sh[FS_W-1] ? ACC_FS_W'(mag) : '0);
      acc_md <= {acc_md[ACC_MD_W-2:0], 1'b0} + (md_sh[FS_W-1] ? ACC_MD_W'(mag) : '0);
    end
  end

  // deadband, saturation and sign
  assign limit   = {deadband, {DB_SHIFT{1'b0}}};
  assign raw_mag = CMD_W'(acc_md >> CMD_SHIFT);
  assign cmd_mag = (raw_mag > CMD_LIMIT) ? CMD_LIMIT : raw_mag;

  always_ff @(posedge clk) begin
    if (fin) begin
      if (acc_fs < ACC_FS_W'(limit)) begin
        cmd <= '0;
      end else if (neg) begin
        cmd <= CMD_W'(-cmd_mag);
      end else begin
        cmd <= cmd_mag;
      end
    end
  end

endmodule

[dv/tb_gyro_window_average_throttle_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gyro_window_average_throttle_top
// Self-checking bench for the windowed gyro average and throttle command.
// A short probe list runs first at the reset register values. Random samples
// follow over a series of register settings, the extremes among them. Each
// accepted sample is run through a local boxcar/duty predictor. Every output
// beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_gyro_window_average_throttle_top import gwat_pkg::*; ();

  localparam int WIN_LEN       = 50;
  localparam int N_PROBES      = 20;
  localparam int N_SETTINGS    = 9;
  localparam int PER_SETTING   = 70;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int IDLE_LIMIT    = 4000;
  localparam int MAX_REPORTS   = 10;

  // index with no register behind it, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_TOGGLE, RX_STARVED} rx_mode_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] avg;
    logic signed [CMD_W-1:0] cmd;
    logic                    full;
  } rate_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       typed;
    rate_t                      rate;
  } probe_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  gyro_x = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [AVG_W-1:0]     average_q8;
  logic signed [CMD_W-1:0]     motor_command;
  logic                        window_full;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  // probes at reset values; results typed in only where they are obvious
  probe_t probe_list [N_PROBES] = '{
    '{16'sh7FFF, 1'b1, '{ 24'sd8388352, 8'sd99, 1'b0}},
    '{16'sh8000, 1'b1, '{-24'sd128,     8'sd0,  1'b0}},
    '{16'sh0000, 1'b1, '{-24'sd85,      8'sd0,  1'b0}},
    '{16'shFFFF, 1'b0, '0}, '{16'sh0001, 1'b0, '0}, '{16'sh5555, 1'b0, '0},
    '{16'shAAAA, 1'b0, '0}, '{16'sh7FFF, 1'b0, '0}, '{16'sh7FFF, 1'b0, '0},
    '{16'sh7FFF, 1'b0, '0}, '{16'sh7FFF, 1'b0, '0}, '{16'sh8000, 1'b0, '0},
    '{16'sh8000, 1'b0, '0}, '{16'sh8000, 1'b0, '0}, '{16'sh8000, 1'b0, '0},
    '{16'sh00FF, 1'b0, '0}, '{16'sh4000, 1'b0, '0}, '{16'shC000, 1'b0, '0},
    '{16'sh7FFE, 1'b0, '0}, '{16'sh8001, 1'b0, '0}
  };

  // predictor state
  logic signed [SAMPLE_W-1:0] sample_hist [WIN_LEN];
  int unsigned                hist_ptr;
  bit                         hist_full;
  longint                     hist_sum;
  logic [DB_W-1:0]            set_deadband;
  logic [FS_W-1:0]            set_full_scale;
  logic [MD_W-1:0]            set_max_duty;

  rate_t expected_rates [$];

  // bookkeeping
  int mismatches;
  int rates_checked;
  int samples_sent;
  int cmds_nonzero;
  int cmds_at_limit;
  int full_windows;
  int hold_asked;
  int burst_left;
  int level;
  int spread;
  int seg_left;

  gyro_window_average_throttle_top #(.WINDOW_LEN(WIN_LEN)) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .gyro_x        (gyro_x),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .average_q8    (average_q8),
    .motor_command (motor_command),
    .window_full   (window_full),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // boxcar average of the last samples, then the deadbanded duty command
  function automatic rate_t predict_rate(input logic signed [SAMPLE_W-1:0] s);
    rate_t  r;
    longint count;
    longint avg;
    longint mag;
    longint duty;
    if (hist_full) begin
      hist_sum -= longint'(sample_hist[hist_ptr]);
    end
    hist_sum += longint'(s);
    sample_hist[hist_ptr] = s;
    count = hist_full ? WIN_LEN : hist_ptr + 1;
    hist_ptr++;
    if (hist_ptr >= WIN_LEN) begin
      hist_ptr  = 0;
      hist_full = 1'b1;
    end
    avg = (hist_sum * 256) / count;
    mag = (avg < 0) ? -avg : avg;
    if (mag * longint'(set_full_scale) < (longint'(set_deadband) <<< DB_SHIFT)) begin
      duty = 0;
    end else begin
      duty = (mag * longint'(set_max_duty)) >>> CMD_SHIFT;
      if (duty > 100) duty = 100;
      if (avg < 0) duty = -duty;
    end
    r.avg  = avg[AVG_W-1:0];
    r.cmd  = duty[CMD_W-1:0];
    r.full = hist_full;
    return r;
  endfunction

  // mostly held rate levels with noise, so the average sweeps the whole range
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int pick;
    int v;
    pick = $urandom_range(99);
    if (seg_left == 0) begin
      level    = int'($urandom_range(65535)) - 32768;
      spread   = 1 << $urandom_range(12);
      seg_left = $urandom_range(10, 60);
    end
    seg_left--;
    if (pick < 70) begin
      v = level + int'($urandom_range(2 * spread)) - spread;
    end else if (pick < 85) begin
      v = int'($urandom_range(65535)) - 32768;
    end else if (pick < 95) begin
      case ($urandom_range(3))
        0:       v = 32767;
        1:       v = -32768;
        2:       v = 0;
        default: v = -1;
      endcase
    end else begin
      v = int'($urandom_range(6)) - 3;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SAMPLE_W-1:0];
  endfunction

  // offer one beat and hold it until taken
  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s, input logic typed,
                              input rate_t typed_rate);
    rate_t r;
    in_valid <= 1'b1;
    gyro_x   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_rate(s);
    expected_rates.push_back(typed ? typed_rate : r);
    samples_sent++;
  endtask

  // bursts of random length with random gaps, now and then a long run
  task automatic pace_sender(input bit setting_done);
    if (burst_left != 0) burst_left--;
    if (burst_left == 0 || setting_done) in_valid <= 1'b0;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(9) == 0) ? 150 : $urandom_range(1, 30);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_DEADBAND:   set_deadband   = data[DB_W-1:0];
      REG_FULL_SCALE: set_full_scale = data[FS_W-1:0];
      REG_MAX_DUTY:   set_max_duty   = data[MD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int db, input int fs, input int md, input bit spare);
    write_reg(REG_DEADBAND, CFG_DATA_W'(db));
    write_reg(REG_FULL_SCALE, CFG_DATA_W'(fs));
    write_reg(REG_MAX_DUTY, CFG_DATA_W'(md));
    if (spare) write_reg(REG_SPARE, '1);
    cfg_we <= 1'b0;
  endtask

  // let every predicted beat come out, then give the block time to settle
  task automatic drain_rates();
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // output checker
  always @(posedge clk) begin
    rate_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_rates.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected beat: avg %0d cmd %0d full %0b",
                   average_q8, motor_command, window_full);
      end else begin
        want = expected_rates.pop_front();
        rates_checked++;
        if (motor_command != 0) cmds_nonzero++;
        if (motor_command == 100 || motor_command == -100) cmds_at_limit++;
        if (window_full) full_windows++;
        if (average_q8 !== want.avg || motor_command !== want.cmd ||
            window_full !== want.full) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch on beat %0d: avg exp %0d got %0d, ",
                      "cmd exp %0d got %0d, full exp %0b got %0b"},
                     rates_checked, $signed(want.avg), average_q8,
                     $signed(want.cmd), motor_command, want.full, window_full);
        end
      end
    end
  end

  // receiver: changing stall patterns, plus long hold-offs on request
  always @(posedge clk) begin
    int       hold_taken;
    int       hold_left;
    int       mode_left;
    rx_mode_t rx_mode;
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:    out_ready <= 1'b1;
        RX_SPARSE:  out_ready <= ($urandom_range(3) != 0);
        RX_TOGGLE:  out_ready <= ~out_ready;
        default:    out_ready <= ($urandom_range(7) == 0);
      endcase
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    int quiet;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d still expected",
                 quiet, expected_rates.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    int db;
    int fs;
    int md;
    hist_ptr       = 0;
    hist_full      = 1'b0;
    hist_sum       = 0;
    set_deadband   = DEADBAND_RST;
    set_full_scale = FULL_SCALE_RST;
    set_max_duty   = MAX_DUTY_RST;
    burst_left     = 5;
    seg_left       = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < N_SETTINGS; k++) begin
      // register settings, extremes first, random ones near the end
      case (k)
        1:       begin db = 0;   fs = 2000; md = 100; end
        2:       begin db = 511; fs = 2047; md = 127; end
        3:       begin db = 0;   fs = 0;    md = 127; end
        4:       begin db = 500; fs = 0;    md = 0;   end
        5:       begin db = 1;   fs = 1;    md = 1;   end
        6:       begin
          db = $urandom_range(500); fs = $urandom_range(1, 2000); md = $urandom_range(127);
        end
        7:       begin
          db = $urandom_range(511); fs = $urandom_range(2047); md = $urandom_range(127);
        end
        default: begin db = 10;  fs = 250;  md = 120; end
      endcase
      if (k != 0) apply_settings(db, fs, md, k == 4);
      if (k == 2 || k == 6) hold_asked++;

      if (k == 0) begin
        for (int p = 0; p < N_PROBES; p++) begin
          offer_sample(probe_list[p].sample, probe_list[p].typed, probe_list[p].rate);
          pace_sender(1'b0);
        end
      end
      for (int i = 0; i < PER_SETTING; i++) begin
        offer_sample(pick_sample(), 1'b0, '0);
        pace_sender(i == PER_SETTING - 1);
      end
      drain_rates();
    end

    if (expected_rates.size() != 0) mismatches++;
    $display("covered %0d samples over %0d register settings, %0d output beats checked",
             samples_sent, N_SETTINGS, rates_checked);
    $display("commands nonzero %0d, at duty limit %0d, full-window beats %0d, mismatches %0d",
             cmds_nonzero, cmds_at_limit, full_windows, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
